@@ rtl/core/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants for the first-fit boundary tag allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W   = 34;   // internal byte address / size width
  localparam int TAG_W    = 32;   // heap word width
  localparam int TAG_WORD = 4;    // bytes per tag
  localparam int MINSIZE  = 16;   // prologue block size
  localparam logic [TAG_W-1:0] TAG_USED = 32'd1;

  // fixed layout of the heap start
  localparam int PRO_HDR   = 12;
  localparam int PRO_FTR   = 24;
  localparam int FIRST_BLK = 28;
  localparam int INIT_BRK  = 32;

  // where a merge sequence hands control back to
  localparam logic [1:0] RET_INIT = 2'd0;
  localparam logic [1:0] RET_TAKE = 2'd1;
  localparam logic [1:0] RET_FREE = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [TAG_W-1:0]  tag_t;

endpackage

@@ rtl/core/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/first_fit_boundary_tag_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator
// Implicit free list heap allocator with header/footer boundary tags.
// ----------------------------------------------------------------------------
// Usage: raise start with in_req_type/in_req_bytes/in_free_addr while busy is
// low; the word is taken at that edge. busy stays high until the answer is
// out. out_valid pulses for exactly one cycle with out_payload_addr and
// out_granted; the receiver cannot stall and must take it then. A free always
// answers 0, not granted.
// The sequencer drives one single-port heap RAM, one access per cycle;
// out_valid rises at the edge where busy drops. An allocate reads and
// checks each block in the first-fit walk, writes the header and footer,
// and the remainder's tags when one is split off; growing the heap writes
// the new block's tags and end marker, then merges it with a free last
// block. A free checks the header and footer, marks both free and merges
// likewise. A null, zero-size or misaligned request answers the cycle
// after it is taken; a bad free answers after its header or footer check.
// Throughput: one request at a time; the next one may start in the cycle the
// answer is shown.
// Reset: after rst_n the RAM is swept to zero, one word a cycle, for
// each of its HEAP_BYTES/4 words, then the prologue, first page and end
// marker are written. busy is high for that whole time.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator #(
  parameter int HEAP_BYTES  = 65536,
  parameter int ALIGN_BYTES = 16,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_req_bytes,
  input  logic [15:0] in_free_addr,
  output logic        out_valid,
  output logic [15:0] out_payload_addr,
  output logic        out_granted
);

  localparam int AW         = ffba_pkg::ADDR_W;
  localparam int TW         = ffba_pkg::TAG_W;
  localparam int HEAP_WORDS = HEAP_BYTES / 4;
  localparam int WIDX_W     = $clog2(HEAP_WORDS);
  localparam int BRK_W      = $clog2(HEAP_BYTES) + 1;

  localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] PAGE_A  = AW'(PAGE_BYTES);
  localparam logic [AW-1:0] AMASK   = AW'(ALIGN_BYTES - 1);
  localparam logic [AW-1:0] TWORD   = AW'(ffba_pkg::TAG_WORD);
  localparam logic [WIDX_W:0] CLR_LAST = (WIDX_W+1)'(HEAP_WORDS - 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLR      = 5'd1;
  localparam logic [4:0] S_INIT_PH  = 5'd2;
  localparam logic [4:0] S_INIT_PF  = 5'd3;
  localparam logic [4:0] S_INIT_END = 5'd4;
  localparam logic [4:0] S_WALK_RD  = 5'd5;
  localparam logic [4:0] S_WALK_CHK = 5'd6;
  localparam logic [4:0] S_GROW     = 5'd7;
  localparam logic [4:0] S_GROW_F   = 5'd8;
  localparam logic [4:0] S_GROW_END = 5'd9;
  localparam logic [4:0] S_MRG_RD1  = 5'd10;
  localparam logic [4:0] S_MRG_RD2  = 5'd11;
  localparam logic [4:0] S_MRG_CHK  = 5'd12;
  localparam logic [4:0] S_MRG_W1   = 5'd13;
  localparam logic [4:0] S_MRG_W2   = 5'd14;
  localparam logic [4:0] S_TAKE_H   = 5'd15;
  localparam logic [4:0] S_TAKE_F   = 5'd16;
  localparam logic [4:0] S_TAKE_RH  = 5'd17;
  localparam logic [4:0] S_TAKE_RF  = 5'd18;
  localparam logic [4:0] S_FREE_RD  = 5'd19;
  localparam logic [4:0] S_FREE_T   = 5'd20;
  localparam logic [4:0] S_FREE_F   = 5'd21;
  localparam logic [4:0] S_FREE_WH  = 5'd22;
  localparam logic [4:0] S_FREE_WF  = 5'd23;

  logic [4:0]          state_r, state_nxt;
  logic [WIDX_W:0]     clr_r, clr_nxt;
  ffba_pkg::addr_t     at_r, at_nxt;
  ffba_pkg::addr_t     size_r, size_nxt;
  ffba_pkg::addr_t     need_r, need_nxt;
  ffba_pkg::tag_t      tag_r, tag_nxt;
  logic [1:0]          ret_r, ret_nxt;
  logic [BRK_W-1:0]    brk_r, brk_nxt;
  logic                ov_r, ov_nxt;
  logic [15:0]         oaddr_r, oaddr_nxt;
  logic                ogrant_r, ogrant_nxt;

  logic                mem_we;
  ffba_pkg::addr_t     mem_addr;
  ffba_pkg::tag_t      mem_wdata, mem_rdata;
  logic [WIDX_W-1:0]   mem_idx;

  function automatic ffba_pkg::addr_t tsize(input ffba_pkg::tag_t t);
    tsize = {{(AW-TW){1'b0}}, t[TW-1:2], 2'b00};
  endfunction

  function automatic ffba_pkg::tag_t mk_tag(input ffba_pkg::addr_t s, input logic used);
    mk_tag = {s[TW-1:2], 1'b0, used};
  endfunction

  function automatic ffba_pkg::addr_t ralign(input ffba_pkg::addr_t n);
    ralign = (n + AMASK) & ~AMASK;
  endfunction

  ffba_pkg::addr_t brk_a, fa_a, ext_a, amt_a, s_a, nsize_a;
  logic            pf, nf, mrg_done;

  assign brk_a = AW'(brk_r);
  assign fa_a  = AW'(in_free_addr);
  assign mem_idx = (state_r == S_CLR) ? clr_r[WIDX_W-1:0] : mem_addr[WIDX_W+1:2];

  ffba_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_heap (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_idx),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    at_nxt     = at_r;
    size_nxt   = size_r;
    need_nxt   = need_r;
    tag_nxt    = tag_r;
    ret_nxt    = ret_r;
    brk_nxt    = brk_r;
    ov_nxt     = 1'b0;
    oaddr_nxt  = oaddr_r;
    ogrant_nxt = ogrant_r;
    mem_we     = 1'b0;
    mem_addr   = at_r;
    mem_wdata  = '0;
    ext_a      = (need_r > PAGE_A) ? need_r : PAGE_A;
    amt_a      = ralign(ext_a);
    s_a        = tsize(mem_rdata);
    pf         = ~tag_r[0];
    nf         = ~mem_rdata[0];
    nsize_a    = size_r + (nf ? s_a : '0) + (pf ? tsize(tag_r) : '0);
    mrg_done   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          oaddr_nxt  = '0;
          ogrant_nxt = 1'b0;
          if (in_req_type) begin
            ret_nxt = ffba_pkg::RET_FREE;
            at_nxt  = fa_a - TWORD;
            if (in_free_addr == '0 || fa_a < AW'(ffba_pkg::INIT_BRK) ||
                ((fa_a - AW'(ffba_pkg::INIT_BRK)) & AMASK) != '0 || fa_a > brk_a) begin
              ov_nxt = 1'b1;
            end else begin
              state_nxt = S_FREE_RD;
            end
          end else if (in_req_bytes == '0) begin
            ov_nxt = 1'b1;
          end else begin
            ret_nxt   = ffba_pkg::RET_TAKE;
            need_nxt  = ralign(AW'(in_req_bytes) + 2 * TWORD);
            at_nxt    = AW'(ffba_pkg::FIRST_BLK);
            state_nxt = S_WALK_RD;
          end
        end
      end
      S_CLR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_INIT_PH;
        end
      end
      S_INIT_PH: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(ffba_pkg::PRO_HDR);
        mem_wdata = mk_tag(AW'(ffba_pkg::MINSIZE), 1'b1);
        state_nxt = S_INIT_PF;
      end
      S_INIT_PF: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(ffba_pkg::PRO_FTR);
        mem_wdata = mk_tag(AW'(ffba_pkg::MINSIZE), 1'b1);
        state_nxt = S_INIT_END;
      end
      S_INIT_END: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(ffba_pkg::FIRST_BLK);
        mem_wdata = ffba_pkg::TAG_USED;
        brk_nxt   = BRK_W'(ffba_pkg::INIT_BRK);
        need_nxt  = '0;
        ret_nxt   = ffba_pkg::RET_INIT;
        state_nxt = S_GROW;
      end
      S_WALK_RD: begin
        // read is issued at at_r; data lands next cycle
        if (at_r + TWORD <= brk_a) begin
          state_nxt = S_WALK_CHK;
        end else begin
          state_nxt = S_GROW;
        end
      end
      S_WALK_CHK: begin
        if (s_a == '0) begin
          state_nxt = S_GROW;
        end else if (!mem_rdata[0] && s_a >= need_r) begin
          size_nxt  = s_a;
          state_nxt = S_TAKE_H;
        end else begin
          at_nxt    = at_r + s_a;
          state_nxt = S_WALK_RD;
        end
      end
      S_GROW: begin
        if (brk_a + amt_a > HEAP_A) begin
          if (ret_r == ffba_pkg::RET_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          mem_we    = 1'b1;
          mem_addr  = brk_a - TWORD;
          mem_wdata = mk_tag(amt_a, 1'b0);
          at_nxt    = brk_a - TWORD;
          size_nxt  = amt_a;
          state_nxt = S_GROW_F;
        end
      end
      S_GROW_F: begin
        mem_we    = 1'b1;
        mem_addr  = at_r + size_r - TWORD;
        mem_wdata = mk_tag(size_r, 1'b0);
        state_nxt = S_GROW_END;
      end
      S_GROW_END: begin
        // new end marker just past the grown block
        mem_we    = 1'b1;
        mem_addr  = at_r + size_r;
        mem_wdata = ffba_pkg::TAG_USED;
        brk_nxt   = BRK_W'(brk_a + size_r);
        state_nxt = S_MRG_RD1;
      end
      S_MRG_RD1: begin
        mem_addr  = at_r - TWORD;
        state_nxt = S_MRG_RD2;
      end
      S_MRG_RD2: begin
        mem_addr  = at_r + size_r;
        tag_nxt   = mem_rdata;
        state_nxt = S_MRG_CHK;
      end
      S_MRG_CHK: begin
        // tag_r: tag before the block, mem_rdata: tag after it
        if (pf || nf) begin
          size_nxt  = nsize_a;
          at_nxt    = pf ? (at_r - tsize(tag_r)) : at_r;
          state_nxt = S_MRG_W1;
        end else begin
          mrg_done = 1'b1;
        end
      end
      S_MRG_W1: begin
        mem_we    = 1'b1;
        mem_wdata = mk_tag(size_r, 1'b0);
        state_nxt = S_MRG_W2;
      end
      S_MRG_W2: begin
        mem_we    = 1'b1;
        mem_addr  = at_r + size_r - TWORD;
        mem_wdata = mk_tag(size_r, 1'b0);
        mrg_done  = 1'b1;
      end
      S_TAKE_H: begin
        mem_we    = 1'b1;
        mem_wdata = mk_tag(need_r, 1'b1);
        state_nxt = S_TAKE_F;
      end
      S_TAKE_F: begin
        mem_we    = 1'b1;
        mem_addr  = at_r + need_r - TWORD;
        mem_wdata = mk_tag(need_r, 1'b1);
        if (size_r > need_r) begin
          state_nxt = S_TAKE_RH;
        end else begin
          ov_nxt     = 1'b1;
          oaddr_nxt  = 16'(at_r + TWORD);
          ogrant_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_TAKE_RH: begin
        mem_we    = 1'b1;
        mem_addr  = at_r + need_r;
        mem_wdata = mk_tag(size_r - need_r, 1'b0);
        state_nxt = S_TAKE_RF;
      end
      S_TAKE_RF: begin
        mem_we     = 1'b1;
        mem_addr   = at_r + size_r - TWORD;
        mem_wdata  = mk_tag(size_r - need_r, 1'b0);
        ov_nxt     = 1'b1;
        oaddr_nxt  = 16'(at_r + TWORD);
        ogrant_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_T;
      end
      S_FREE_T: begin
        tag_nxt  = mem_rdata;
        size_nxt = s_a;
        mem_addr = at_r + s_a - TWORD;
        if (!mem_rdata[0] || s_a == '0 || (s_a & AMASK) != '0 ||
            at_r + s_a + TWORD > brk_a) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FREE_F;
        end
      end
      S_FREE_F: begin
        // footer must match header, else not a live block
        if (mem_rdata != tag_r) begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mk_tag(size_r, 1'b0);
          state_nxt = S_FREE_WF;
        end
      end
      S_FREE_WF: begin
        mem_we    = 1'b1;
        mem_addr  = at_r + size_r - TWORD;
        mem_wdata = mk_tag(size_r, 1'b0);
        state_nxt = S_MRG_RD1;
      end
      S_FREE_WH: begin
        state_nxt = S_FREE_WF;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mrg_done) begin
      case (ret_r)
        ffba_pkg::RET_TAKE: state_nxt = S_TAKE_H;
        ffba_pkg::RET_FREE: begin
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      brk_r   <= BRK_W'(ffba_pkg::INIT_BRK);
      ret_r   <= ffba_pkg::RET_INIT;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      brk_r   <= brk_nxt;
      ret_r   <= ret_nxt;
    end
    at_r     <= at_nxt;
    size_r   <= size_nxt;
    need_r   <= need_nxt;
    tag_r    <= tag_nxt;
    oaddr_r  <= oaddr_nxt;
    ogrant_r <= ogrant_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_payload_addr = oaddr_r;
  assign out_granted      = ogrant_r;

endmodule
